/* sv/eac_pkg.sv */
`default_nettype none

package eac_pkg;

   localparam int LEN_WIDTH  = 7;
   localparam int CHAR_WIDTH = 8;
   localparam int CODE_WIDTH = 4;

   localparam logic [LEN_WIDTH-1:0] MAX_LENGTH_RESET = 7'd50;
   localparam logic [LEN_WIDTH-1:0] COUNT_MAX        = 7'd127;

   localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'd32;
   localparam logic [CHAR_WIDTH-1:0] CH_DASH  = 8'd45;
   localparam logic [CHAR_WIDTH-1:0] CH_DOT   = 8'd46;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'd57;
   localparam logic [CHAR_WIDTH-1:0] CH_AT    = 8'd64;
   localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'd65;
   localparam logic [CHAR_WIDTH-1:0] CH_UP_Z  = 8'd90;
   localparam logic [CHAR_WIDTH-1:0] CH_UNDER = 8'd95;
   localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'd97;
   localparam logic [CHAR_WIDTH-1:0] CH_LO_Z  = 8'd122;

   localparam logic [1:0] CHERR_NONE    = 2'd0;
   localparam logic [1:0] CHERR_SPACE   = 2'd1;
   localparam logic [1:0] CHERR_ILLEGAL = 2'd2;

   localparam logic [CODE_WIDTH-1:0] ERR_OK           = 4'd0;
   localparam logic [CODE_WIDTH-1:0] ERR_EMPTY        = 4'd1;
   localparam logic [CODE_WIDTH-1:0] ERR_SPACE        = 4'd2;
   localparam logic [CODE_WIDTH-1:0] ERR_ILLEGAL      = 4'd3;
   localparam logic [CODE_WIDTH-1:0] ERR_TOO_LONG     = 4'd4;
   localparam logic [CODE_WIDTH-1:0] ERR_NO_AT        = 4'd5;
   localparam logic [CODE_WIDTH-1:0] ERR_AT_FIRST     = 4'd6;
   localparam logic [CODE_WIDTH-1:0] ERR_SHORT_NAME   = 4'd7;
   localparam logic [CODE_WIDTH-1:0] ERR_NO_DOT       = 4'd8;
   localparam logic [CODE_WIDTH-1:0] ERR_DOT_AFTER_AT = 4'd9;
   localparam logic [CODE_WIDTH-1:0] ERR_SHORT_DOMAIN = 4'd10;
   localparam logic [CODE_WIDTH-1:0] ERR_DOT_LAST     = 4'd11;
   localparam logic [CODE_WIDTH-1:0] ERR_BAD_TLD      = 4'd12;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_MAX_LENGTH = 1'b0;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  is_end;
   } item_type;

   function automatic logic is_letter(input logic [CHAR_WIDTH-1:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
   endfunction

   function automatic logic is_legal(input logic [CHAR_WIDTH-1:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_AT && c <= CH_UP_Z) ||
             (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_DASH || c == CH_DOT ||
             c == CH_UNDER;
   endfunction

endpackage

`default_nettype wire

/* sv/eac_tracker.sv */
`default_nettype none

module eac_tracker
   import eac_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire item_type              item,
   input  wire logic [LEN_WIDTH-1:0]  max_length,
   output logic      [CODE_WIDTH-1:0] code
);

   logic [LEN_WIDTH-1:0]  length_count_ff, length_count_in;
   logic                  length_over_ff, length_over_in;
   logic [1:0]            char_error_ff, char_error_in;
   logic                  at_seen_ff, at_seen_in;
   logic [LEN_WIDTH-1:0]  at_position_ff, at_position_in;
   logic [CHAR_WIDTH-1:0] first_char_ff, first_char_in;
   logic [CHAR_WIDTH-1:0] char_after_at_ff, char_after_at_in;
   logic                  domain_dot_seen_ff, domain_dot_seen_in;
   logic [LEN_WIDTH-1:0]  domain_gap_ff, domain_gap_in;
   logic                  first_dot_seen_ff, first_dot_seen_in;
   logic [CHAR_WIDTH-1:0] after_dot_char_ff, after_dot_char_in;
   logic [1:0]            capture_phase_ff, capture_phase_in;

   always_comb begin
      length_count_in    = length_count_ff;
      length_over_in     = length_over_ff;
      char_error_in      = char_error_ff;
      at_seen_in         = at_seen_ff;
      at_position_in     = at_position_ff;
      first_char_in      = first_char_ff;
      char_after_at_in   = char_after_at_ff;
      domain_dot_seen_in = domain_dot_seen_ff;
      domain_gap_in      = domain_gap_ff;
      first_dot_seen_in  = first_dot_seen_ff;
      after_dot_char_in  = after_dot_char_ff;
      capture_phase_in   = capture_phase_ff;
      if (step && item.is_end) begin
         length_count_in    = '0;
         length_over_in     = 1'b0;
         char_error_in      = CHERR_NONE;
         at_seen_in         = 1'b0;
         at_position_in     = '0;
         first_char_in      = '0;
         char_after_at_in   = '0;
         domain_dot_seen_in = 1'b0;
         domain_gap_in      = '0;
         first_dot_seen_in  = 1'b0;
         after_dot_char_in  = '0;
         capture_phase_in   = '0;
      end else if (step) begin
         if (char_error_ff == CHERR_NONE) begin
            if (item.ch == CH_SPACE) begin
               char_error_in = CHERR_SPACE;
            end else if (!is_legal(item.ch)) begin
               char_error_in = CHERR_ILLEGAL;
            end
         end
         if (length_count_ff == '0 && !length_over_ff) begin
            first_char_in = item.ch;
         end
         if (capture_phase_ff[0]) begin
            char_after_at_in = item.ch;
         end
         if (capture_phase_ff[1]) begin
            after_dot_char_in = item.ch;
         end
         capture_phase_in = '0;
         if (at_seen_ff && !domain_dot_seen_ff) begin
            if (item.ch == CH_DOT) begin
               domain_dot_seen_in = 1'b1;
            end else if (domain_gap_ff != COUNT_MAX) begin
               domain_gap_in = domain_gap_ff + 1'b1;
            end
         end
         if (!at_seen_ff && item.ch == CH_AT) begin
            at_seen_in          = 1'b1;
            at_position_in      = length_count_ff;
            capture_phase_in[0] = 1'b1;
         end
         if (!first_dot_seen_ff && item.ch == CH_DOT) begin
            first_dot_seen_in   = 1'b1;
            capture_phase_in[1] = 1'b1;
         end
         if (length_count_ff == COUNT_MAX) begin
            length_over_in = 1'b1;
         end else begin
            length_count_in = length_count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      if (length_count_ff == '0 && !length_over_ff) begin
         code = ERR_EMPTY;
      end else if (char_error_ff == CHERR_SPACE) begin
         code = ERR_SPACE;
      end else if (char_error_ff != CHERR_NONE) begin
         code = ERR_ILLEGAL;
      end else if (length_over_ff || length_count_ff > max_length) begin
         code = ERR_TOO_LONG;
      end else if (!at_seen_ff) begin
         code = ERR_NO_AT;
      end else if (at_position_ff == '0) begin
         code = ERR_AT_FIRST;
      end else if (at_position_ff == LEN_WIDTH'(1) && !is_letter(first_char_ff)) begin
         code = ERR_SHORT_NAME;
      end else if (!domain_dot_seen_ff) begin
         code = ERR_NO_DOT;
      end else if (domain_gap_ff == '0) begin
         code = ERR_DOT_AFTER_AT;
      end else if (domain_gap_ff == LEN_WIDTH'(1) && !is_letter(char_after_at_ff)) begin
         code = ERR_SHORT_DOMAIN;
      end else if (after_dot_char_ff == '0) begin
         code = ERR_DOT_LAST;
      end else if (!is_letter(after_dot_char_ff)) begin
         code = ERR_BAD_TLD;
      end else begin
         code = ERR_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_count_ff    <= '0;
         length_over_ff     <= 1'b0;
         char_error_ff      <= CHERR_NONE;
         at_seen_ff         <= 1'b0;
         at_position_ff     <= '0;
         first_char_ff      <= '0;
         char_after_at_ff   <= '0;
         domain_dot_seen_ff <= 1'b0;
         domain_gap_ff      <= '0;
         first_dot_seen_ff  <= 1'b0;
         after_dot_char_ff  <= '0;
         capture_phase_ff   <= '0;
      end else begin
         length_count_ff    <= length_count_in;
         length_over_ff     <= length_over_in;
         char_error_ff      <= char_error_in;
         at_seen_ff         <= at_seen_in;
         at_position_ff     <= at_position_in;
         first_char_ff      <= first_char_in;
         char_after_at_ff   <= char_after_at_in;
         domain_dot_seen_ff <= domain_dot_seen_in;
         domain_gap_ff      <= domain_gap_in;
         first_dot_seen_ff  <= first_dot_seen_in;
         after_dot_char_ff  <= after_dot_char_in;
         capture_phase_ff   <= capture_phase_in;
      end
   end

endmodule

`default_nettype wire

/* sv/email_address_checker.sv */
// A result appears on rsp_valid after the end transaction passes the input and result registers.
// One transaction per cycle; an end transaction stalls while a result awaits rsp_ready.
// An input register and a result register separate the two channels.
// Reset is synchronous and active high; it clears all running state and sets
// max_length to 50.
`default_nettype none

module email_address_checker
   import eac_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [CHAR_WIDTH-1:0]     req_ch,
   input  wire logic                      req_is_end,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid_res,
   output logic      [CODE_WIDTH-1:0]     rsp_error_code,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready
);

   logic                  max_length_en;
   logic [LEN_WIDTH-1:0]  max_length_reg_ff;
   logic                  stage_valid_ff, stage_valid_in;
   item_type              stage_item_ff;
   logic                  stage_advance;
   logic                  out_load;
   logic                  out_valid_ff, out_valid_in;
   logic [CODE_WIDTH-1:0] out_code_ff;
   logic [CODE_WIDTH-1:0] verdict_code;

   assign pready        = 1'b1;
   assign max_length_en = psel && penable && pwrite && pready &&
                          paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_MAX_LENGTH;

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_WIDTH-1] == CSR_IDX_MAX_LENGTH) begin
         prdata[LEN_WIDTH-1:0] = max_length_reg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_reg_ff <= MAX_LENGTH_RESET;
      end else if (max_length_en) begin
         max_length_reg_ff <= pwdata[LEN_WIDTH-1:0];
      end
   end

   assign stage_advance  = stage_valid_ff &&
                           (!stage_item_ff.is_end || !out_valid_ff || rsp_ready);
   assign req_ready      = !stage_valid_ff || stage_advance;
   assign stage_valid_in = (req_valid && req_ready) || (stage_valid_ff && !stage_advance);
   assign out_load       = stage_advance && stage_item_ff.is_end;
   assign out_valid_in   = out_load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_item_ff.ch     <= req_ch;
         stage_item_ff.is_end <= req_is_end;
      end
      if (out_load) begin
         out_code_ff <= verdict_code;
      end
   end

   eac_tracker u_tracker (
      .clock      (clock),
      .reset      (reset),
      .step       (stage_advance),
      .item       (stage_item_ff),
      .max_length (max_length_reg_ff),
      .code       (verdict_code)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_error_code = out_code_ff;
   assign rsp_valid_res  = (out_code_ff == ERR_OK);

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_error_code <= ERR_BAD_TLD)
      else $error("result code out of range");

   a_end_blocks: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && stage_item_ff.is_end && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("end transaction overran a waiting result");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_code_ff)))
      else $error("waiting result was overwritten");

endmodule

`default_nettype wire
